>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is held (active-low reset)
`define TSFQ_ASSERT(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("tsfq assertion failed");

// Clocked check, active through reset as well
`define TSFQ_ASSERT_ALWAYS(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("tsfq assertion failed");

`else

`define TSFQ_ASSERT(lbl, clk_sig, rstn_sig, prop)
`define TSFQ_ASSERT_ALWAYS(lbl, clk_sig, prop)

`endif

`endif

>>> hdl/tsfq_pkg.sv
// ----------------------------------------------------------------------------
// tsfq_pkg
// Shared types and field widths for the timestamped frame queue.
// ----------------------------------------------------------------------------
package tsfq_pkg;

  // Field widths of one frame descriptor and of the result beat
  localparam int unsigned PTS_W   = 64;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned HDL_W   = 32;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned COUNT_W = 7;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_FLUSH = 2'd2,
    FN_RSVD  = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_EMPTY   = 3'd0,
    ST_POPPED  = 3'd1,
    ST_PUSHED  = 3'd2,
    ST_DROPPED = 3'd3,
    ST_FLUSHED = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPW,
    S_FCMP,
    S_HOLD
  } state_t;

endpackage

>>> hdl/tsfq_in_if.sv
// ----------------------------------------------------------------------------
// tsfq_in_if
// Request channel: one operation beat with its frame descriptor and floor.
// ----------------------------------------------------------------------------
interface tsfq_in_if;
  logic                           valid;
  logic                           ready;
  logic [tsfq_pkg::FUNC_W-1:0]    func;
  logic [tsfq_pkg::PTS_W-1:0]     frame_pts;
  logic [tsfq_pkg::LEN_W-1:0]     frame_length;
  logic [tsfq_pkg::HDL_W-1:0]     payload_handle;
  logic [tsfq_pkg::PTS_W-1:0]     floor_time;

  modport source (
    output valid, func, frame_pts, frame_length, payload_handle, floor_time,
    input  ready
  );
  modport sink (
    input  valid, func, frame_pts, frame_length, payload_handle, floor_time,
    output ready
  );
endinterface

>>> hdl/tsfq_out_if.sv
// ----------------------------------------------------------------------------
// tsfq_out_if
// Result channel: status, popped descriptor and entry count.
// ----------------------------------------------------------------------------
interface tsfq_out_if;
  logic                           valid;
  logic                           ready;
  logic [tsfq_pkg::STAT_W-1:0]    status;
  logic [tsfq_pkg::PTS_W-1:0]     out_pts;
  logic [tsfq_pkg::LEN_W-1:0]     out_length;
  logic [tsfq_pkg::HDL_W-1:0]     out_handle;
  logic [tsfq_pkg::COUNT_W-1:0]   entry_count;

  modport source (
    output valid, status, out_pts, out_length, out_handle, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, out_pts, out_length, out_handle, entry_count,
    output ready
  );
endinterface

>>> hdl/tsfq_ram.sv
// ----------------------------------------------------------------------------
// tsfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsfq_ram #(
  parameter int unsigned WIDTH = 109,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/timestamped_frame_queue_drop_oldest_unit.sv
// ----------------------------------------------------------------------------
// timestamped_frame_queue_drop_oldest_unit
// Circular queue of timestamped frame descriptors with drop-oldest overflow.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one operation per beat: push (pts, length, handle),
//   pop of the head frame, or flush below floor_time. out_chan returns
//   exactly one result beat per operation: status, the popped descriptor
//   (zero unless a frame was popped) and the entry count afterwards.
//   in_chan.ready is high only while the sequencer is idle; one operation
//   is in flight, and the next beat is taken in the cycle its result first
//   shows valid.
//   Push, unused code, flush with a zero floor or on an empty queue and
//   pop on an empty queue finish in the execute state.
//   Pop of a frame adds the pop-wait state for one registered read of
//   the descriptor RAM. Flush with a nonzero floor walks the head in the
//   compare state until an entry is not below the floor or the walk
//   empties the queue; the single RAM read port and one 64-bit comparator
//   set its rate, one head entry per cycle.
//   Reset clears the indices and count; descriptor RAM is not cleared.
//   A stalled result sits in the output register; a second finished result
//   is parked in a hold stage, and no new beat is accepted until it moves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timestamped_frame_queue_drop_oldest_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  tsfq_in_if.sink           in_chan,
  tsfq_out_if.source        out_chan
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = tsfq_pkg::PTS_W + tsfq_pkg::LEN_W + tsfq_pkg::HDL_W;

  // Sequencer and queue pointers
  tsfq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;
  logic [AW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    occ_r, occ_nxt;

  // Captured request
  tsfq_pkg::func_t             func_r;
  logic [tsfq_pkg::PTS_W-1:0]  pts_r;
  logic [tsfq_pkg::LEN_W-1:0]  len_r;
  logic [tsfq_pkg::HDL_W-1:0]  hdl_r;
  logic [tsfq_pkg::PTS_W-1:0]  floor_r;

  // RAM
  logic          mem_we;
  logic [MW-1:0] mem_wdata;
  logic [MW-1:0] mem_rdata;
  logic [tsfq_pkg::PTS_W-1:0] rd_pts;
  logic [tsfq_pkg::LEN_W-1:0] rd_len;
  logic [tsfq_pkg::HDL_W-1:0] rd_hdl;

  // Result of the finishing step
  logic                          done;
  tsfq_pkg::status_t             res_status;
  logic [tsfq_pkg::PTS_W-1:0]    res_pts;
  logic [tsfq_pkg::LEN_W-1:0]    res_len;
  logic [tsfq_pkg::HDL_W-1:0]    res_hdl;
  logic [tsfq_pkg::COUNT_W-1:0]  res_count;

  // Hold stage for a result finished while the output is stalled
  tsfq_pkg::status_t             hold_status_r;
  logic [tsfq_pkg::PTS_W-1:0]    hold_pts_r;
  logic [tsfq_pkg::LEN_W-1:0]    hold_len_r;
  logic [tsfq_pkg::HDL_W-1:0]    hold_hdl_r;
  logic [tsfq_pkg::COUNT_W-1:0]  hold_count_r;

  // Output register
  logic                          out_valid_r;
  tsfq_pkg::status_t             out_status_r;
  logic [tsfq_pkg::PTS_W-1:0]    out_pts_r;
  logic [tsfq_pkg::LEN_W-1:0]    out_len_r;
  logic [tsfq_pkg::HDL_W-1:0]    out_hdl_r;
  logic [tsfq_pkg::COUNT_W-1:0]  out_count_r;

  logic in_fire;
  logic out_free;
  logic pts_below;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
    if (idx == AW'(DEPTH - 1)) begin
      return '0;
    end
    return idx + 1'b1;
  endfunction

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == tsfq_pkg::S_IDLE);

  // Descriptor storage; read address follows the next head so a walk
  // issues one read per cycle
  assign mem_wdata = {pts_r, len_r, hdl_r};
  assign {rd_pts, rd_len, rd_hdl} = mem_rdata;

  tsfq_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r),
    .wdata (mem_wdata),
    .raddr (head_nxt),
    .rdata (mem_rdata)
  );

  // Shared comparator: head timestamp against the flush floor
  assign pts_below = (rd_pts < floor_r);

  // Datapath and result for the current sequencer step
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    mem_we     = 1'b0;
    done       = 1'b0;
    res_status = tsfq_pkg::ST_EMPTY;
    res_pts    = '0;
    res_len    = '0;
    res_hdl    = '0;
    case (state_r)
      tsfq_pkg::S_EXEC: begin
        case (func_r)
          tsfq_pkg::FN_PUSH: begin
            mem_we   = 1'b1;
            done     = 1'b1;
            tail_nxt = next_idx(tail_r);
            if (occ_r == CW'(DEPTH)) begin
              // full: oldest entry is overwritten
              head_nxt   = next_idx(head_r);
              res_status = tsfq_pkg::ST_DROPPED;
            end else begin
              occ_nxt    = occ_r + 1'b1;
              res_status = tsfq_pkg::ST_PUSHED;
            end
          end
          tsfq_pkg::FN_POP: begin
            // nonempty: read of head is issued this cycle
            if (occ_r == '0) begin
              done = 1'b1;
            end
          end
          tsfq_pkg::FN_FLUSH: begin
            res_status = tsfq_pkg::ST_FLUSHED;
            if (floor_r == '0) begin
              head_nxt = '0;
              tail_nxt = '0;
              occ_nxt  = '0;
              done     = 1'b1;
            end else if (occ_r == '0) begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      tsfq_pkg::S_POPW: begin
        done       = 1'b1;
        res_status = tsfq_pkg::ST_POPPED;
        res_pts    = rd_pts;
        res_len    = rd_len;
        res_hdl    = rd_hdl;
        head_nxt   = next_idx(head_r);
        occ_nxt    = occ_r - 1'b1;
      end
      tsfq_pkg::S_FCMP: begin
        res_status = tsfq_pkg::ST_FLUSHED;
        if (pts_below) begin
          head_nxt = next_idx(head_r);
          occ_nxt  = occ_r - 1'b1;
          if (occ_r == CW'(1)) begin
            done = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res_count = tsfq_pkg::COUNT_W'(occ_nxt);
  end

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsfq_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = tsfq_pkg::S_EXEC;
        end
      end
      tsfq_pkg::S_EXEC: begin
        if (done) begin
          state_nxt = out_free ? tsfq_pkg::S_IDLE : tsfq_pkg::S_HOLD;
        end else if (func_r == tsfq_pkg::FN_POP) begin
          state_nxt = tsfq_pkg::S_POPW;
        end else begin
          state_nxt = tsfq_pkg::S_FCMP;
        end
      end
      tsfq_pkg::S_POPW: begin
        state_nxt = out_free ? tsfq_pkg::S_IDLE : tsfq_pkg::S_HOLD;
      end
      tsfq_pkg::S_FCMP: begin
        if (done) begin
          state_nxt = out_free ? tsfq_pkg::S_IDLE : tsfq_pkg::S_HOLD;
        end
      end
      tsfq_pkg::S_HOLD: begin
        if (out_free) begin
          state_nxt = tsfq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsfq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsfq_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      if ((done || state_r == tsfq_pkg::S_HOLD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture, hold stage and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= tsfq_pkg::func_t'(in_chan.func);
      pts_r   <= in_chan.frame_pts;
      len_r   <= in_chan.frame_length;
      hdl_r   <= in_chan.payload_handle;
      floor_r <= in_chan.floor_time;
    end
    if (done && !out_free) begin
      hold_status_r <= res_status;
      hold_pts_r    <= res_pts;
      hold_len_r    <= res_len;
      hold_hdl_r    <= res_hdl;
      hold_count_r  <= res_count;
    end
    if (done && out_free) begin
      out_status_r <= res_status;
      out_pts_r    <= res_pts;
      out_len_r    <= res_len;
      out_hdl_r    <= res_hdl;
      out_count_r  <= res_count;
    end else if (state_r == tsfq_pkg::S_HOLD && out_free) begin
      out_status_r <= hold_status_r;
      out_pts_r    <= hold_pts_r;
      out_len_r    <= hold_len_r;
      out_hdl_r    <= hold_hdl_r;
      out_count_r  <= hold_count_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.out_pts     = out_pts_r;
  assign out_chan.out_length  = out_len_r;
  assign out_chan.out_handle  = out_hdl_r;
  assign out_chan.entry_count = out_count_r;

  // Checks
  `TSFQ_ASSERT(a_occ_bound, clk, rst_n, occ_r <= CW'(DEPTH))
  `TSFQ_ASSERT(a_ptr_meet, clk, rst_n, (head_r == tail_r) == (occ_r == '0 || occ_r == CW'(DEPTH)))
  `TSFQ_ASSERT(a_walk_nonempty, clk, rst_n, (state_r == tsfq_pkg::S_FCMP) |-> (occ_r != '0))
  `TSFQ_ASSERT(a_busy_after_accept, clk, rst_n, in_fire |=> !in_chan.ready)
  `TSFQ_ASSERT(a_hold_stalled, clk, rst_n, (state_r == tsfq_pkg::S_HOLD) |-> out_valid_r)

endmodule

>>> dv/tsfq_queue_checker.sv
// ----------------------------------------------------------------------------
// tsfq_queue_checker
// Watches the request and result channels of the frame queue, keeps a mirror
// of the descriptor ring and checks each result beat field by field.
// ----------------------------------------------------------------------------
module tsfq_queue_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tsfq_in_if          in_chan,
  tsfq_out_if         out_chan,
  output int unsigned fail_count,
  output int unsigned pending_results
);

  typedef logic [tsfq_pkg::PTS_W-1:0] field_t;

  typedef struct {
    tsfq_pkg::status_t                status;
    logic [tsfq_pkg::PTS_W-1:0]       pts;
    logic [tsfq_pkg::LEN_W-1:0]       length;
    logic [tsfq_pkg::HDL_W-1:0]       handle;
    logic [tsfq_pkg::COUNT_W-1:0]     count;
  } queue_result_t;

  // Mirror of the descriptor ring
  logic [tsfq_pkg::PTS_W-1:0] pts_mirror    [DEPTH];
  logic [tsfq_pkg::LEN_W-1:0] length_mirror [DEPTH];
  logic [tsfq_pkg::HDL_W-1:0] handle_mirror [DEPTH];
  int unsigned      head_slot;
  int unsigned      tail_slot;
  int unsigned      depth_used;

  queue_result_t    expected_q[$];
  int unsigned      errors;

  assign fail_count = errors;

  function automatic int unsigned wrap_next(int unsigned slot);
    return (slot + 1) % DEPTH;
  endfunction

  // Apply one operation to the mirror and return the result it should give
  function automatic queue_result_t run_queue_op(tsfq_pkg::func_t op,
                                                 logic [tsfq_pkg::PTS_W-1:0] pts,
                                                 logic [tsfq_pkg::LEN_W-1:0] length,
                                                 logic [tsfq_pkg::HDL_W-1:0] handle,
                                                 logic [tsfq_pkg::PTS_W-1:0] floor_val);
    queue_result_t res;
    res.status = tsfq_pkg::ST_EMPTY;
    res.pts    = '0;
    res.length = '0;
    res.handle = '0;
    case (op)
      tsfq_pkg::FN_PUSH: begin
        res.status = tsfq_pkg::ST_PUSHED;
        // full ring: oldest frame goes first
        if (depth_used == DEPTH) begin
          head_slot  = wrap_next(head_slot);
          depth_used--;
          res.status = tsfq_pkg::ST_DROPPED;
        end
        pts_mirror[tail_slot]    = pts;
        length_mirror[tail_slot] = length;
        handle_mirror[tail_slot] = handle;
        tail_slot = wrap_next(tail_slot);
        depth_used++;
      end
      tsfq_pkg::FN_POP: begin
        if (depth_used != 0) begin
          res.status = tsfq_pkg::ST_POPPED;
          res.pts    = pts_mirror[head_slot];
          res.length = length_mirror[head_slot];
          res.handle = handle_mirror[head_slot];
          head_slot  = wrap_next(head_slot);
          depth_used--;
        end
      end
      tsfq_pkg::FN_FLUSH: begin
        res.status = tsfq_pkg::ST_FLUSHED;
        if (floor_val == '0) begin
          head_slot  = 0;
          tail_slot  = 0;
          depth_used = 0;
        end else begin
          // strictly below the floor goes; equal stays
          while (depth_used != 0 && pts_mirror[head_slot] < floor_val) begin
            head_slot = wrap_next(head_slot);
            depth_used--;
          end
        end
      end
      default: ;  // unused code: no state change
    endcase
    res.count = depth_used[tsfq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  task automatic check_field(string field, field_t want, field_t got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Result beats are checked before the request beat of the same edge:
  // a request can never be answered at the edge that accepts it.
  always @(posedge clk) begin : beat_monitor
    queue_result_t want;
    if (!rst_n) begin
      head_slot  = 0;
      tail_slot  = 0;
      depth_used = 0;
      expected_q.delete();
    end else begin
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: expected none, actual status %0d",
                   $time, out_chan.status);
        end else begin
          want = expected_q.pop_front();
          check_field("status", field_t'(want.status), field_t'(out_chan.status));
          check_field("out_pts", want.pts, out_chan.out_pts);
          check_field("out_length", field_t'(want.length), field_t'(out_chan.out_length));
          check_field("out_handle", field_t'(want.handle), field_t'(out_chan.out_handle));
          check_field("entry_count", field_t'(want.count), field_t'(out_chan.entry_count));
        end
      end
      if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1)
        expected_q.push_back(run_queue_op(tsfq_pkg::func_t'(in_chan.func), in_chan.frame_pts,
                                          in_chan.frame_length, in_chan.payload_handle,
                                          in_chan.floor_time));
    end
    pending_results <= expected_q.size();
  end

endmodule

>>> dv/tb_timestamped_frame_queue_drop_oldest_unit.sv
// ----------------------------------------------------------------------------
// tb_timestamped_frame_queue_drop_oldest_unit
// Drives push, pop, flush and unused-code beats into the frame queue with
// random idle gaps and result back-pressure; the checker judges the results.
// ----------------------------------------------------------------------------
module tb_timestamped_frame_queue_drop_oldest_unit;

  typedef logic [tsfq_pkg::PTS_W-1:0] pts_t;
  typedef logic [tsfq_pkg::LEN_W-1:0] len_t;
  typedef logic [tsfq_pkg::HDL_W-1:0] hdl_t;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned FRAME_NS = 21_333_333;   // one audio frame period
  localparam pts_t        PTS_MAX  = '1;

  logic             clk = 1'b0;
  logic             rst_n;
  int unsigned      fail_count;
  int unsigned      pending_results;
  bit               idle_gaps;
  pts_t             stream_pts;

  tsfq_in_if  in_chan ();
  tsfq_out_if out_chan ();

  timestamped_frame_queue_drop_oldest_unit #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tsfq_queue_checker #(.DEPTH(DEPTH)) queue_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_chan         (in_chan),
    .out_chan        (out_chan),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Floors mostly land inside the recent stream window
  function automatic pts_t pick_floor();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6)  return '0;
    if (roll < 14) return {$urandom, $urandom};
    if (roll < 18) return PTS_MAX;
    return stream_pts - $urandom_range(0, 40) * FRAME_NS + $urandom_range(0, FRAME_NS);
  endfunction

  // One request beat; unused fields carry random values
  task automatic send_op(tsfq_pkg::func_t op, pts_t pts, len_t length,
                         hdl_t handle, pts_t floor_val);
    int unsigned gap;
    gap = idle_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.func           <= op;
    in_chan.frame_pts      <= pts;
    in_chan.frame_length   <= length;
    in_chan.payload_handle <= handle;
    in_chan.floor_time     <= floor_val;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
  endtask

  task automatic push_frame(pts_t pts, len_t length, hdl_t handle);
    send_op(tsfq_pkg::FN_PUSH, pts, length, handle, {$urandom, $urandom});
  endtask

  task automatic pop_frame();
    send_op(tsfq_pkg::FN_POP, {$urandom, $urandom}, len_t'($urandom), $urandom,
            {$urandom, $urandom});
  endtask

  task automatic flush_below(pts_t floor_val);
    send_op(tsfq_pkg::FN_FLUSH, {$urandom, $urandom}, len_t'($urandom), $urandom,
            floor_val);
  endtask

  task automatic send_unused();
    send_op(tsfq_pkg::FN_RSVD, {$urandom, $urandom}, len_t'($urandom), $urandom,
            {$urandom, $urandom});
  endtask

  // Next frame of a steady audio stream; some arrive late, behind the stream
  task automatic push_stream_frame();
    pts_t pts;
    stream_pts += FRAME_NS + $urandom_range(0, 40_000);
    pts = stream_pts;
    if ($urandom_range(0, 9) == 0)
      pts = stream_pts - $urandom_range(1, 8) * FRAME_NS;
    push_frame(pts, len_t'($urandom_range(60, 1500)), $urandom);
  endtask

  // Result side: random stalls, steady stretches and two long hold-offs
  initial begin : result_drain
    int unsigned stall_left;
    int unsigned beats;
    bit          steady;
    out_chan.ready <= 1'b0;
    stall_left = 0;
    beats      = 0;
    steady     = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        beats++;
        if (beats % 50 == 0)
          steady = ($urandom_range(0, 2) == 0);
        // long hold-off: sender keeps offering, queue backs up into the input
        if (beats == 90 || beats == 300)
          stall_left = 240;
        else if (!steady)
          stall_left = pick_gap();
      end else if (!steady && stall_left == 0 && $urandom_range(0, 19) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned profile;
    int unsigned roll;
    int unsigned push_pct;
    in_chan.valid          <= 1'b0;
    in_chan.func           <= tsfq_pkg::FN_PUSH;
    in_chan.frame_pts      <= '0;
    in_chan.frame_length   <= '0;
    in_chan.payload_handle <= '0;
    in_chan.floor_time     <= '0;
    rst_n                  <= 1'b0;
    idle_gaps  = 1'b1;
    stream_pts = {$urandom_range(0, 65535), $urandom};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue: pop, both kinds of flush, unused code
    pop_frame();
    flush_below('0);
    flush_below(PTS_MAX);
    send_unused();

    // Field extremes in and back out in order
    push_frame('0, '0, '0);
    push_frame(PTS_MAX, '1, '1);
    pop_frame();
    pop_frame();

    // Floor walk stops at the first frame not below the floor
    push_frame(64'd100, len_t'($urandom), $urandom);
    push_frame(64'd200, len_t'($urandom), $urandom);
    push_frame(64'd50, len_t'($urandom), $urandom);
    push_frame(64'd300, len_t'($urandom), $urandom);
    flush_below(64'd150);     // drops 100, stops at 200
    flush_below(64'd200);     // head equals floor: kept
    send_unused();
    flush_below(PTS_MAX);     // walk empties the queue
    push_frame(stream_pts, len_t'($urandom), $urandom);
    push_frame(stream_pts + FRAME_NS, len_t'($urandom), $urandom);
    flush_below('0);
    pop_frame();

    // Overfill so the oldest frames get dropped, then trim
    repeat (DEPTH + 6) push_stream_frame();
    repeat (4) pop_frame();
    flush_below(stream_pts - 20 * FRAME_NS);
    repeat (3) pop_frame();

    // Random chunks with fill, drain, balanced and noise profiles
    for (int chunk = 0; chunk < 9; chunk++) begin
      profile   = $urandom_range(0, 3);
      idle_gaps = ($urandom_range(0, 3) != 0);
      case (profile)
        0:       push_pct = 80;
        1:       push_pct = 30;
        default: push_pct = 55;
      endcase
      for (int n = 0; n < 40; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          if (profile == 3)
            push_frame({$urandom, $urandom}, len_t'($urandom), $urandom);
          else
            push_stream_frame();
        end else if (roll < 92) begin
          pop_frame();
        end else if (roll < 98) begin
          flush_below(pick_floor());
        end else begin
          send_unused();
        end
      end
    end

    // Drain and look for stray beats
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("[timestamped_frame_queue_drop_oldest_unit] OK");
    else
      $display("[timestamped_frame_queue_drop_oldest_unit] ERROR");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[timestamped_frame_queue_drop_oldest_unit] ERROR");
    $finish;
  end

endmodule
